>>> design/brbs_pkg.sv
// Package for the buddy region block splitter: sizes, result kinds and the
// order-pick interface struct. It depends on nothing else.
package brbs_pkg;

  // Block configuration.
  localparam int MAX_ARENAS   = 8;
  localparam int PAGE_BYTES   = 4096;
  localparam int META_BYTES   = 12;
  localparam int RESULT_LIMIT = 40;

  localparam logic [31:0] VOFFSET_RESET = 32'hC000_0000;
  localparam logic [31:0] FREE_TYPE     = 32'h0000_0001;

  // Derived widths. Addresses of a region end need 33 bits.
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 33;
  localparam int PAGES_W    = ADDR_W - PAGE_SHIFT;
  localparam int CUR_W      = 32 - PAGE_SHIFT;
  localparam int MAX_ORDER  = 31 - PAGE_SHIFT;
  localparam int ORDER_W    = 5;
  localparam int ARENA_W    = 3;
  localparam int COUNT_W    = $clog2(MAX_ARENAS + 1);
  localparam int RESULT_W   = $clog2(RESULT_LIMIT);
  localparam int META_W     = $clog2(META_BYTES + 1);
  localparam int PROD_W     = PAGES_W + META_W + 1;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_FREE      = 3'd0,
    KIND_SKIPPED   = 3'd1,
    KIND_TOO_SMALL = 3'd2,
    KIND_NO_SLOT   = 3'd3,
    KIND_EMPTY     = 3'd4
  } kind_t;

  // Order chosen for the next free block.
  typedef struct packed {
    logic [ORDER_W-1:0] order;   // block holds 2^order pages
    logic [PAGES_W-1:0] step;    // 2^order, in pages
    logic               drains;  // the block uses up every remaining page
  } pick_t;

endpackage

>>> design/brbs_order_pick.sv
// Order picker: largest block order that is aligned, fits the remaining pages
// and does not pass the arena's max order. Depends on brbs_pkg.
module brbs_order_pick (
  input  logic [brbs_pkg::CUR_W-1:0]   cur_pages,
  input  logic [brbs_pkg::PAGES_W-1:0] rem_pages,
  input  logic [brbs_pkg::ORDER_W-1:0] order_cap,
  input  logic                         align_ok,
  output brbs_pkg::pick_t              pick
);

  // Alignment and fit are both monotone in the order, so the highest order
  // that passes every test is the answer; order 0 is the fallback.
  always_comb begin
    logic [brbs_pkg::ORDER_W-1:0] ord;
    ord = '0;
    for (int o = 1; o <= brbs_pkg::MAX_ORDER; o++) begin
      if (align_ok &&
          (brbs_pkg::ORDER_W'(o) <= order_cap) &&
          ((cur_pages & brbs_pkg::CUR_W'((1 << o) - 1)) == '0) &&
          ((rem_pages >> o) != '0)) begin
        ord = brbs_pkg::ORDER_W'(o);
      end
    end
    pick.order  = ord;
    pick.step   = brbs_pkg::PAGES_W'(1) << ord;
    pick.drains = (rem_pages == pick.step);
  end

endmodule

>>> design/buddy_region_block_splitter_unit.sv
// Top level of the buddy region block splitter: sequencer, order search,
// metadata reservation and the output register. Uses brbs_pkg, brbs_order_pick.
//
// Each accepted item is one memory-map entry. Skipped, too small and
// no-slot entries give one result and hold the input stalled through the
// round, classify and report states. An accepted arena holds the input
// stalled through round, classify, the order search, metadata, place and
// emit; the order search tests one doubling block size against the length
// per cycle, up to 20 steps, and the emitter produces one free block per
// cycle while the output is not stalled, at most 40 results. The next entry
// is taken while the last result of the previous one still waits in the output
// register. virtual_offset may be written whenever no entry is in work.
module buddy_region_block_splitter_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] region_base,
  input  logic [63:0] region_length,
  input  logic [31:0] region_type,
  input  logic        end_of_map,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [2:0]  arena_index,
  output logic [31:0] block_address,
  output logic [4:0]  block_order,
  output logic [4:0]  arena_max_order,
  output logic        last
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ROUND    = 8'b0000_0010,
    ST_CLASSIFY = 8'b0000_0100,
    ST_SEARCH   = 8'b0000_1000,
    ST_META     = 8'b0001_0000,
    ST_PLACE    = 8'b0010_0000,
    ST_EMIT     = 8'b0100_0000,
    ST_REPORT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0] virtual_offset;
  logic [brbs_pkg::COUNT_W-1:0] arena_count;

  // Entry registers
  logic [31:0] base_lo;
  logic [31:0] len_lo;
  logic        skip;
  logic        eom;
  logic [brbs_pkg::ADDR_W-1:0] abase;
  logic [brbs_pkg::ADDR_W-1:0] end_addr;
  logic [brbs_pkg::ADDR_W-1:0] alen;
  logic [brbs_pkg::ADDR_W-1:0] size;
  logic [brbs_pkg::COUNT_W-1:0] arena_slot;
  logic [brbs_pkg::ORDER_W-1:0] arena_order;
  logic [brbs_pkg::PAGES_W-1:0] meta_pages;
  logic [brbs_pkg::PAGES_W-1:0] phys_pages;
  logic [brbs_pkg::PAGES_W-1:0] rem_pages;
  logic [brbs_pkg::CUR_W-1:0]   cur_pages;
  logic        align_ok;
  logic [brbs_pkg::RESULT_W-1:0] n_results;
  brbs_pkg::kind_t rep_kind;

  // Combinational helpers
  logic accept;
  logic out_free;
  logic load;
  logic too_small;
  logic no_slot;
  logic grow;
  logic empty;
  logic final_result;
  logic [brbs_pkg::PROD_W-1:0] meta_prod;
  logic [brbs_pkg::PROD_W-1:0] meta_round;
  brbs_pkg::pick_t pick;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign load      = ((state == ST_EMIT) || (state == ST_REPORT)) && out_free;
  assign too_small = (abase >= end_addr);
  assign no_slot   = (arena_count >= brbs_pkg::COUNT_W'(brbs_pkg::MAX_ARENAS));

  // One step of the order search: does the next larger block fit the length?
  assign grow = (arena_order < brbs_pkg::ORDER_W'(brbs_pkg::MAX_ORDER)) &&
                ({1'b0, len_lo} >= size);

  // Metadata pages: ceil(pages * META_BYTES / PAGE_BYTES).
  assign meta_prod  = brbs_pkg::PROD_W'(alen[brbs_pkg::ADDR_W-1:brbs_pkg::PAGE_SHIFT]) *
                      brbs_pkg::PROD_W'(brbs_pkg::META_BYTES);
  assign meta_round = meta_prod + brbs_pkg::PROD_W'(brbs_pkg::PAGE_BYTES - 1);

  assign empty        = (rem_pages == '0);
  assign final_result = empty || pick.drains ||
                        (n_results == brbs_pkg::RESULT_W'(brbs_pkg::RESULT_LIMIT - 1));

  brbs_order_pick u_pick (
    .cur_pages (cur_pages),
    .rem_pages (rem_pages),
    .order_cap (arena_order),
    .align_ok  (align_ok),
    .pick      (pick)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (skip || too_small || no_slot) state_next = ST_REPORT;
        else state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!grow) state_next = ST_META;
      end
      ST_META: begin
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && final_result) state_next = ST_IDLE;
      end
      ST_REPORT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: state, arena count, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      arena_count    <= '0;
      virtual_offset <= brbs_pkg::VOFFSET_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) virtual_offset <= cfg_wdata;
      // An accepted arena takes a slot; the end of the map frees them all.
      if (state == ST_CLASSIFY) begin
        if (eom) arena_count <= '0;
        else if (!skip && !too_small && !no_slot) arena_count <= arena_count + 1'b1;
      end
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Datapath registers of the entry in work.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_lo <= region_base[31:0];
      len_lo  <= region_length[31:0];
      skip    <= (region_base[63:32] != '0) || (region_length[63:32] != '0) ||
                 (region_type != brbs_pkg::FREE_TYPE);
      eom     <= end_of_map;
    end
    // Round the base up to a page and form the 33-bit end address.
    if (state == ST_ROUND) begin
      abase    <= ({1'b0, base_lo} + brbs_pkg::ADDR_W'(brbs_pkg::PAGE_BYTES - 1)) &
                  ~brbs_pkg::ADDR_W'(brbs_pkg::PAGE_BYTES - 1);
      end_addr <= {1'b0, base_lo} + {1'b0, len_lo};
    end
    // Classify the entry and prime the order search.
    if (state == ST_CLASSIFY) begin
      if (skip) rep_kind <= brbs_pkg::KIND_SKIPPED;
      else if (too_small) rep_kind <= brbs_pkg::KIND_TOO_SMALL;
      else rep_kind <= brbs_pkg::KIND_NO_SLOT;
      alen        <= end_addr - abase;
      arena_slot  <= arena_count;
      arena_order <= '0;
      size        <= brbs_pkg::ADDR_W'(2 * brbs_pkg::PAGE_BYTES);
    end
    if ((state == ST_SEARCH) && grow) begin
      arena_order <= arena_order + 1'b1;
      size        <= size << 1;
    end
    if (state == ST_META) begin
      meta_pages <= brbs_pkg::PAGES_W'(meta_round >> brbs_pkg::PAGE_SHIFT);
    end
    // Skip the metadata pages; track the physical and virtual page positions.
    if (state == ST_PLACE) begin
      phys_pages <= abase[brbs_pkg::ADDR_W-1:brbs_pkg::PAGE_SHIFT] + meta_pages;
      rem_pages  <= alen[brbs_pkg::ADDR_W-1:brbs_pkg::PAGE_SHIFT] - meta_pages;
      cur_pages  <= abase[brbs_pkg::PAGE_SHIFT+brbs_pkg::CUR_W-1:brbs_pkg::PAGE_SHIFT] +
                    meta_pages[brbs_pkg::CUR_W-1:0] +
                    virtual_offset[31:brbs_pkg::PAGE_SHIFT];
      align_ok   <= (virtual_offset[brbs_pkg::PAGE_SHIFT-1:0] == '0);
      n_results  <= '0;
    end
    // Carve one block per emitted item.
    if ((state == ST_EMIT) && out_free && !empty) begin
      phys_pages <= phys_pages + pick.step;
      cur_pages  <= cur_pages + pick.step[brbs_pkg::CUR_W-1:0];
      rem_pages  <= rem_pages - pick.step;
      n_results  <= n_results + 1'b1;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      if (state == ST_REPORT) begin
        kind            <= rep_kind;
        arena_index     <= '0;
        block_address   <= '0;
        block_order     <= '0;
        arena_max_order <= '0;
        last            <= 1'b1;
      end else if (empty) begin
        kind            <= brbs_pkg::KIND_EMPTY;
        arena_index     <= brbs_pkg::ARENA_W'(arena_slot);
        block_address   <= '0;
        block_order     <= '0;
        arena_max_order <= arena_order;
        last            <= 1'b1;
      end else begin
        kind            <= brbs_pkg::KIND_FREE;
        arena_index     <= brbs_pkg::ARENA_W'(arena_slot);
        block_address   <= {phys_pages[brbs_pkg::CUR_W-1:0], {brbs_pkg::PAGE_SHIFT{1'b0}}};
        block_order     <= pick.order;
        arena_max_order <= arena_order;
        last            <= final_result;
      end
    end
  end

`ifndef ASSERT_OFF
  // The slot count saturates at the number of arenas.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    arena_count <= brbs_pkg::COUNT_W'(brbs_pkg::MAX_ARENAS))
    else $error("arena count passed its limit");

  // A free block never exceeds the arena's max order.
  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == brbs_pkg::KIND_FREE) |-> block_order <= arena_max_order)
    else $error("block order above arena max order");

  // Every block shrinks the remaining pages without wrapping.
  a_rem_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && out_free && !empty |=> rem_pages < $past(rem_pages))
    else $error("remaining pages did not shrink");

  // Every result other than a free block is the entry's final one.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != brbs_pkg::KIND_FREE) |-> last)
    else $error("single result without last");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for buddy_region_block_splitter_unit.
// Depends on brbs_pkg and the unit itself; it holds its own block-splitting predictor.

module tb_top;

  // One memory-map entry as offered on the input channel.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] rtype;
    logic        eom;
  } map_entry_t;

  // One result as seen on the output channel.
  typedef struct packed {
    brbs_pkg::kind_t kind;
    logic [2:0]      arena;
    logic [31:0]     addr;
    logic [4:0]      order;
    logic [4:0]      arena_order;
    logic            last;
  } block_result_t;

  // A directed entry, with a typed-in result where one is obvious.
  typedef struct packed {
    map_entry_t    entry;
    logic          typed;
    block_result_t want;
  } plan_row_t;

  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] region_base = '0;
  logic [63:0] region_length = '0;
  logic [31:0] region_type = '0;
  logic        end_of_map = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [2:0]  arena_index;
  logic [31:0] block_address;
  logic [4:0]  block_order;
  logic [4:0]  arena_max_order;
  logic        last;

  // Predictor state and the blocks still owed by the unit.
  logic [3:0]    arena_slots;
  logic [31:0]   vaddr_offset;
  block_result_t planned_q[$];
  block_result_t owed_blocks[$];
  plan_row_t     directed_rows[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int entries_sent = 0;
  int results_seen = 0;
  int free_blocks = 0;
  int slot_refusals = 0;
  int empty_arenas = 0;

  buddy_region_block_splitter_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .region_base    (region_base),
    .region_length  (region_length),
    .region_type    (region_type),
    .end_of_map     (end_of_map),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .arena_index    (arena_index),
    .block_address  (block_address),
    .block_order    (block_order),
    .arena_max_order(arena_max_order),
    .last           (last)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A single-result answer with all payload fields at zero.
  function automatic block_result_t lone_result(input brbs_pkg::kind_t k);
    return '{k, 3'd0, 32'd0, 5'd0, 5'd0, 1'b1};
  endfunction

  // Work out the results of one map entry and advance the arena count.
  task automatic plan_region(input map_entry_t e);
    logic [63:0] pg, abase, end_addr, alen, npages, meta_pages, phys, left, cur, sz;
    logic [4:0] top_order, ord;
    logic [2:0] slot;
    block_result_t tail;
    planned_q.delete();
    pg = 64'(brbs_pkg::PAGE_BYTES);
    if (e.base[63:32] != '0 || e.length[63:32] != '0 || e.rtype != brbs_pkg::FREE_TYPE) begin
      planned_q.push_back(lone_result(brbs_pkg::KIND_SKIPPED));
    end else begin
      abase = ((e.base + pg - 64'd1) / pg) * pg;
      end_addr = e.base + e.length;
      if (abase >= end_addr) begin
        planned_q.push_back(lone_result(brbs_pkg::KIND_TOO_SMALL));
      end else if (arena_slots >= 4'(brbs_pkg::MAX_ARENAS)) begin
        planned_q.push_back(lone_result(brbs_pkg::KIND_NO_SLOT));
      end else begin
        slot = arena_slots[2:0];
        // Largest order whose block fits the original length, below 4 GB.
        top_order = '0;
        sz = 2 * pg;
        while (sz <= 64'hFFFF_FFFF && sz <= e.length) begin
          top_order++;
          sz = sz * 2;
        end
        // Metadata pages come off the front of the rounded region.
        alen = end_addr - abase;
        npages = alen / pg;
        meta_pages = (npages * 64'(brbs_pkg::META_BYTES) + pg - 64'd1) / pg;
        phys = abase + meta_pages * pg;
        left = alen - meta_pages * pg;
        // Cut the rest into the largest aligned blocks that still fit.
        while (left >= pg && planned_q.size() < brbs_pkg::RESULT_LIMIT) begin
          cur = (phys + 64'(vaddr_offset)) & 64'hFFFF_FFFF;
          ord = top_order;
          sz = (64'd1 << ord) * pg;
          while (ord > 0 && !((cur % sz) == 0 && sz <= left)) begin
            ord--;
            sz = sz / 2;
          end
          planned_q.push_back('{brbs_pkg::KIND_FREE, slot, phys[31:0], ord, top_order, 1'b0});
          phys = phys + sz;
          left = left - sz;
        end
        if (planned_q.size() == 0) begin
          planned_q.push_back('{brbs_pkg::KIND_EMPTY, slot, 32'd0, 5'd0, top_order, 1'b1});
        end else begin
          tail = planned_q.pop_back();
          tail.last = 1'b1;
          planned_q.push_back(tail);
        end
        arena_slots = arena_slots + 4'd1;
      end
    end
    if (e.eom) begin
      arena_slots = '0;
    end
  endtask

  // Mostly well-formed usable regions of mixed size, plus broken and noisy entries.
  function automatic map_entry_t random_entry();
    map_entry_t e;
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    e.base = {32'd0, $urandom};
    if ($urandom_range(0, 1) == 0) begin
      e.base[11:0] = '0;
    end
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 32) : $urandom_range(12, 23);
    e.length = {32'd0, $urandom} >> (32 - span);
    e.rtype = brbs_pkg::FREE_TYPE;
    e.eom = ($urandom_range(0, 15) == 0);
    if (pick < 10) begin
      e.base = {$urandom, $urandom};
      e.length = {$urandom, $urandom};
      e.rtype = $urandom;
    end else if (pick < 16) begin
      case ($urandom_range(0, 2))
        0: e.base[63:32] = $urandom_range(1, 32'hFFFF_FFFF);
        1: e.length[63:32] = $urandom_range(1, 32'hFFFF_FFFF);
        default: begin
          e.rtype = $urandom;
          if (e.rtype == brbs_pkg::FREE_TYPE) begin
            e.rtype = '0;
          end
        end
      endcase
    end else if (pick < 24) begin
      e.length = 64'($urandom_range(0, brbs_pkg::PAGE_BYTES - 1));
    end
    return e;
  endfunction

  task automatic add_row(input logic [63:0] base, input logic [63:0] length,
                         input logic [31:0] rtype, input logic eom,
                         input logic typed, input block_result_t want);
    directed_rows.push_back('{'{base, length, rtype, eom}, typed, want});
  endtask

  // Present one item, wait for it to be taken, then record what it owes.
  task automatic offer_entry(input map_entry_t e, input logic typed,
                             input block_result_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    region_base <= e.base;
    region_length <= e.length;
    region_type <= e.rtype;
    end_of_map <= e.eom;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    plan_region(e);
    if (typed) begin
      owed_blocks.push_back(want);
    end else begin
      foreach (planned_q[i]) begin
        owed_blocks.push_back(planned_q[i]);
      end
    end
    entries_sent++;
  endtask

  // Let every owed result come out, plus a short quiet stretch.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_blocks.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_offset(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vaddr_offset = value;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        gap_pct = 19;
        stall_pct = 71;
      end
      1: begin
        gap_pct = 71;
        stall_pct = 19;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted result with the oldest owed one.
  always @(posedge clk) begin : result_check
    block_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (kind == brbs_pkg::KIND_FREE) free_blocks++;
      if (kind == brbs_pkg::KIND_NO_SLOT) slot_refusals++;
      if (kind == brbs_pkg::KIND_EMPTY) empty_arenas++;
      if (owed_blocks.size() == 0) begin
        $error("result with nothing owed: kind %0d, address 0x%0h", kind, block_address);
        mismatches++;
      end else begin
        want = owed_blocks.pop_front();
        check_field("kind", want.kind, kind);
        check_field("arena_index", want.arena, arena_index);
        check_field("block_address", want.addr, block_address);
        check_field("block_order", want.order, block_order);
        check_field("arena_max_order", want.arena_order, arena_max_order);
        check_field("last", want.last, last);
      end
    end
  end

  // Directed entries, then random phases under different offsets and idling.
  initial begin : stimulus
    logic [31:0] phase_offset [NUM_PHASES];
    block_result_t none;
    none = lone_result(brbs_pkg::KIND_FREE);
    phase_offset[0] = 32'h0000_0000;
    phase_offset[1] = 32'hFFFF_FFFF;
    phase_offset[2] = 32'h0000_3000;
    phase_offset[3] = $urandom;
    phase_offset[4] = 32'h8000_0000;
    phase_offset[5] = $urandom & 32'hFFFF_F000;

    // Single page region whose only page goes to metadata.
    add_row(64'h1000, 64'h1000, brbs_pkg::FREE_TYPE, 1'b0, 1'b1,
            '{brbs_pkg::KIND_EMPTY, 3'd0, 32'd0, 5'd0, 5'd0, 1'b1});
    // Reserved types, addresses or lengths beyond 32 bits.
    add_row(64'h0, 64'h2_0000, 32'h0, 1'b0, 1'b1, lone_result(brbs_pkg::KIND_SKIPPED));
    add_row(64'h0, 64'h2_0000, 32'hFFFF_FFFF, 1'b0, 1'b1,
            lone_result(brbs_pkg::KIND_SKIPPED));
    add_row(64'h1_0000_0000, 64'h1000, brbs_pkg::FREE_TYPE, 1'b0, 1'b1,
            lone_result(brbs_pkg::KIND_SKIPPED));
    add_row('1, '1, '1, 1'b0, 1'b1, lone_result(brbs_pkg::KIND_SKIPPED));
    add_row(64'h0, 64'h1_0000_0000, brbs_pkg::FREE_TYPE, 1'b0, 1'b1,
            lone_result(brbs_pkg::KIND_SKIPPED));
    // Regions that vanish once the base is rounded up.
    add_row(64'h0, 64'h0, brbs_pkg::FREE_TYPE, 1'b0, 1'b1,
            lone_result(brbs_pkg::KIND_TOO_SMALL));
    add_row(64'h1001, 64'h100, brbs_pkg::FREE_TYPE, 1'b0, 1'b1,
            lone_result(brbs_pkg::KIND_TOO_SMALL));
    add_row(64'hFFFF_FFFF, 64'h1, brbs_pkg::FREE_TYPE, 1'b0, 1'b1,
            lone_result(brbs_pkg::KIND_TOO_SMALL));
    // Whole 4 GB space, an end past 4 GB, and ordinary arenas up to the slot limit.
    add_row(64'h0, 64'hFFFF_FFFF, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);
    add_row(64'hFFFF_F000, 64'hFFFF_FFFF, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);
    add_row(64'h10_0000, 64'h1_0000, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);
    add_row(64'h1234_5678, 64'h40_0000, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);
    add_row(64'h800, 64'h2800, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);
    add_row(64'h2000, 64'h2000, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);
    add_row(64'h3000, 64'h5000, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);
    add_row(64'h8000, 64'h8000, brbs_pkg::FREE_TYPE, 1'b0, 1'b1,
            lone_result(brbs_pkg::KIND_NO_SLOT));
    // End of map restarts the arena numbering.
    add_row(64'h0, 64'h0, brbs_pkg::FREE_TYPE, 1'b1, 1'b1,
            lone_result(brbs_pkg::KIND_TOO_SMALL));
    add_row(64'h1000, 64'h1000, brbs_pkg::FREE_TYPE, 1'b1, 1'b1,
            '{brbs_pkg::KIND_EMPTY, 3'd0, 32'd0, 5'd0, 5'd0, 1'b1});
    add_row(64'h2000, 64'h1000, 32'h2, 1'b1, 1'b1, lone_result(brbs_pkg::KIND_SKIPPED));
    add_row(64'h4000_0000, 64'h4000_0000, brbs_pkg::FREE_TYPE, 1'b0, 1'b0, none);

    arena_slots = '0;
    vaddr_offset = brbs_pkg::VOFFSET_RESET;
    set_idling(0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_entry(directed_rows[i].entry, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_offset(phase_offset[phase]);
      set_idling(phase / 2);
      repeat (PHASE_ITEMS) offer_entry(random_entry(), 1'b0, none);
      drain();
    end

    $display("Sent %0d map entries under %0d offset settings and three idling patterns.",
             entries_sent, NUM_PHASES + 1);
    $display("Checked %0d results: %0d free blocks, %0d empty arenas, %0d slot refusals.",
             results_seen, free_blocks, empty_arenas, slot_refusals);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
